FILE: rtl/nlr_pkg.sv
package nlr_pkg;

  // Fixed field widths
  localparam int VALUE_W = 24;
  localparam int COEF_W  = 24;
  localparam int SINE_W  = 19;
  localparam int COS_W   = 18;
  localparam int IDX_W   = 4;

  // Shared multiplier operand and product widths
  localparam int OPA_W  = 32;
  localparam int OPB_W  = 25;
  localparam int PROD_W = 66;

  // Fixed-point one in Q.18
  localparam logic signed [VALUE_W-1:0] ONE_Q18 = VALUE_W'(1 << 18);

  typedef struct packed {
    logic signed [SINE_W-1:0] sine_of_latitude;
    logic        [COS_W-1:0]  cosine_of_latitude;
  } latitude_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] function_value;
    logic        [IDX_W-1:0]   degree_n;
    logic        [IDX_W-1:0]   order_m;
    logic                      last_of_run;
  } result_t;

  // Round half up then shift right by k
  function automatic logic signed [PROD_W-1:0] rnd(input logic signed [PROD_W-1:0] x,
                                                   input int k);
    logic signed [PROD_W-1:0] half;
    half = PROD_W'(1) <<< (k - 1);
    return (x + half) >>> k;
  endfunction

  // Clamp to the signed value range
  function automatic logic signed [VALUE_W-1:0] sat(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = (PROD_W'(1) <<< (VALUE_W - 1)) - PROD_W'(1);
    lo = -hi - PROD_W'(1);
    if (x > hi) return hi[VALUE_W-1:0];
    if (x < lo) return lo[VALUE_W-1:0];
    return x[VALUE_W-1:0];
  endfunction

endpackage

FILE: rtl/nlr_coef_rom.sv
// Recurrence coefficient table, contents fixed at elaboration, registered read
module nlr_coef_rom #(
  parameter int TRUNCATION = 7
) (
  input  logic                                                 clk,
  input  logic [$clog2(2*(TRUNCATION+2)*(TRUNCATION+2))-1:0]   addr,
  output logic [nlr_pkg::COEF_W-1:0]                           data
);

  localparam int DIM    = TRUNCATION + 2;
  localparam int DEPTH  = 2 * DIM * DIM;

  // restoring division, elaboration only
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    int i;
    q = 0;
    rem = 0;
    for (i = 63; i >= 0; i--) begin
      rem = (rem << 1) | ((num >> i) & 64'd1);
      if (rem >= den) begin
        rem = rem - den;
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    longint unsigned x;
    int i;
    x = v;
    r = 0;
    for (i = 31; i >= 0; i--) begin
      b = 64'd1 << (2 * i);
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned root_ratio(input longint unsigned num,
                                                 input longint unsigned den);
    if (den == 0) return 0;
    return isqrt(udiv(num << 36, den));
  endfunction

  function automatic logic [nlr_pkg::COEF_W-1:0] coef_at(input int idx);
    longint unsigned a;
    longint unsigned b;
    longint unsigned v;
    int m;
    int n;
    v = 0;
    for (m = 0; m <= TRUNCATION; m++) begin
      for (n = m + 1; n <= TRUNCATION + 1; n++) begin
        a = 4 * n * n - 1;
        b = n * n - m * m;
        if (idx == n * DIM + m) v = root_ratio(a, b);
        if (idx == DIM * DIM + n * DIM + m) v = root_ratio(b, a);
      end
      if (m >= 1 && idx == m * DIM + m) v = root_ratio(1, 2 * m);
    end
    return v[nlr_pkg::COEF_W-1:0];
  endfunction

  logic [nlr_pkg::COEF_W-1:0] rom_w [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    localparam logic [nlr_pkg::COEF_W-1:0] V = coef_at(i);
    assign rom_w[i] = V;
  end

  // registered read
  always_ff @(posedge clk) begin
    data <= rom_w[addr];
  end

endmodule

FILE: rtl/normalized_legendre_recurrence.sv
// Normalized associated Legendre recurrence for one latitude. Pulse start with
// the sine and cosine (Q1.17) while busy is low; the block then emits every
// P(n,m) for m = 0..TRUNCATION in order, one value per result_valid pulse, the
// final one flagged last_of_run. The receiver cannot stall the stream: each
// result is present for exactly one cycle. All arithmetic runs through one
// shared registered multiplier, so each value is worked out over a sequence
// of states: the seed, the P(m+1,m) step, the recurrence steps and the diagonal
// steps. busy rises after the accepted start and drops in the cycle that shows
// the last value, so the next start can be taken at the end of that cycle.
module normalized_legendre_recurrence #(
  parameter int TRUNCATION = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  nlr_pkg::latitude_t  latitude,
  output logic                busy,
  output logic                result_valid,
  output nlr_pkg::result_t    result
);

  localparam int DIM    = TRUNCATION + 2;
  localparam int HALF   = DIM * DIM;
  localparam int ADDR_W = $clog2(2 * DIM * DIM);
  localparam logic [nlr_pkg::IDX_W-1:0] M_LAST = nlr_pkg::IDX_W'(TRUNCATION);
  localparam logic [nlr_pkg::IDX_W-1:0] N_LAST = nlr_pkg::IDX_W'(TRUNCATION + 1);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'h0001,
    ST_SEED   = 15'h0002,
    ST_P1_MUL = 15'h0004,
    ST_P1_OUT = 15'h0008,
    ST_REC_Z  = 15'h0010,
    ST_REC_A  = 15'h0020,
    ST_REC_B  = 15'h0040,
    ST_REC_F  = 15'h0080,
    ST_REC_P  = 15'h0100,
    ST_DG_C   = 15'h0200,
    ST_DG_A   = 15'h0400,
    ST_DG_M   = 15'h0800,
    ST_DG_F   = 15'h1000,
    ST_DG_D   = 15'h2000,
    ST_DG_S   = 15'h4000
  } state_t;

  state_t state, state_next;

  logic signed [nlr_pkg::SINE_W-1:0]  s;
  logic        [nlr_pkg::COS_W-1:0]   c;
  logic signed [nlr_pkg::VALUE_W-1:0] diag, prev, sprev;
  logic        [nlr_pkg::COEF_W-1:0]  z;
  logic signed [nlr_pkg::OPA_W-1:0]   work;
  logic signed [nlr_pkg::PROD_W-1:0]  acc, prod_q;
  logic        [nlr_pkg::IDX_W-1:0]   m, n;
  logic        [ADDR_W-1:0]           addr, addr_next;
  logic        [nlr_pkg::COEF_W-1:0]  coef;

  logic signed [nlr_pkg::OPA_W-1:0]   mul_a;
  logic signed [nlr_pkg::OPB_W-1:0]   mul_b;
  logic signed [nlr_pkg::OPB_W-1:0]   coef_s, z_s, c_s;
  logic signed [nlr_pkg::PROD_W-1:0]  rnd17, rnd18, t_full;
  logic signed [nlr_pkg::VALUE_W-1:0] p17, p18;
  logic        [nlr_pkg::IDX_W-1:0]   m_inc;

  function automatic logic [ADDR_W-1:0] addr_of(input logic inv_sel,
                                                input logic [nlr_pkg::IDX_W-1:0] nn,
                                                input logic [nlr_pkg::IDX_W-1:0] mm);
    int a;
    a = int'(nn) * DIM + int'(mm) + (inv_sel ? HALF : 0);
    return ADDR_W'(a);
  endfunction

  nlr_coef_rom #(.TRUNCATION(TRUNCATION)) u_rom (
    .clk  (clk),
    .addr (addr_next),
    .data (coef)
  );

  assign busy   = (state != ST_IDLE);
  assign coef_s = $signed({1'b0, coef});
  assign z_s    = $signed({1'b0, z});
  assign c_s    = nlr_pkg::OPB_W'($signed({1'b0, c}));
  assign rnd17  = nlr_pkg::rnd(prod_q, 17);
  assign rnd18  = nlr_pkg::rnd(prod_q, 18);
  assign p17    = nlr_pkg::sat(rnd17);
  assign p18    = nlr_pkg::sat(rnd18);
  assign t_full = nlr_pkg::rnd(acc - prod_q, 18);
  assign m_inc  = m + nlr_pkg::IDX_W'(1);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_P1_MUL: begin mul_a = nlr_pkg::OPA_W'(diag);  mul_b = nlr_pkg::OPB_W'(s); end
      ST_REC_Z:  begin mul_a = nlr_pkg::OPA_W'(prev);  mul_b = nlr_pkg::OPB_W'(s); end
      ST_REC_A:  begin mul_a = nlr_pkg::OPA_W'(sprev); mul_b = z_s; end
      ST_REC_F:  begin mul_a = work;                   mul_b = coef_s; end
      ST_DG_C:   begin mul_a = nlr_pkg::OPA_W'(diag);  mul_b = c_s; end
      ST_DG_M:   begin mul_a = work;                   mul_b = coef_s; end
      ST_DG_D:   begin mul_a = nlr_pkg::OPA_W'(sprev); mul_b = coef_s; end
      default:   begin mul_a = '0;                     mul_b = '0; end
    endcase
  end

  // sequencer next state and coefficient address
  always_comb begin
    state_next = state;
    addr_next  = addr;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SEED;
          addr_next  = addr_of(1'b0, nlr_pkg::IDX_W'(1), '0);
        end
      end
      ST_SEED:   state_next = ST_P1_MUL;
      ST_P1_MUL: state_next = ST_P1_OUT;
      ST_P1_OUT: begin
        if (m == M_LAST) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_REC_Z;
          addr_next  = addr_of(1'b1, m_inc, m);
        end
      end
      ST_REC_Z: state_next = ST_REC_A;
      ST_REC_A: state_next = ST_REC_B;
      ST_REC_B: begin
        state_next = ST_REC_F;
        addr_next  = addr_of(1'b0, n, m);
      end
      ST_REC_F: state_next = ST_REC_P;
      ST_REC_P: begin
        if (n == N_LAST) begin
          state_next = ST_DG_C;
          addr_next  = addr_of(1'b0, m_inc, m_inc);
        end else begin
          state_next = ST_REC_Z;
          addr_next  = addr_of(1'b1, n, m);
        end
      end
      ST_DG_C: state_next = ST_DG_A;
      ST_DG_A: state_next = ST_DG_M;
      ST_DG_M: begin
        state_next = ST_DG_F;
        addr_next  = addr_of(1'b0, m_inc, m);
      end
      ST_DG_F: state_next = ST_DG_D;
      ST_DG_D: state_next = ST_DG_S;
      ST_DG_S: state_next = ST_P1_MUL;
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_SEED) || (state == ST_P1_OUT) ||
                      (state == ST_REC_P) || (state == ST_DG_F);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    addr   <= addr_next;
    prod_q <= nlr_pkg::PROD_W'(mul_a * mul_b);
    case (state)
      ST_IDLE: begin
        if (start) begin
          s <= latitude.sine_of_latitude;
          c <= latitude.cosine_of_latitude;
        end
      end
      ST_SEED: begin
        diag   <= nlr_pkg::sat(nlr_pkg::PROD_W'($signed({1'b0, coef})));
        sprev  <= nlr_pkg::ONE_Q18;
        m      <= '0;
        result <= '{function_value: nlr_pkg::ONE_Q18, degree_n: '0, order_m: '0,
                    last_of_run: 1'b0};
      end
      ST_P1_OUT: begin
        prev   <= p17;
        n      <= m + nlr_pkg::IDX_W'(2);
        result <= '{function_value: p17, degree_n: m_inc, order_m: m,
                    last_of_run: (m == M_LAST)};
      end
      ST_REC_Z: z    <= coef;
      ST_REC_A: acc  <= prod_q <<< 1;
      ST_REC_B: work <= t_full[nlr_pkg::OPA_W-1:0];
      ST_REC_P: begin
        sprev  <= prev;
        prev   <= p18;
        result <= '{function_value: p18, degree_n: n, order_m: m, last_of_run: 1'b0};
        if (n == N_LAST) begin
          m <= m_inc;
        end else begin
          n <= n + nlr_pkg::IDX_W'(1);
        end
      end
      ST_DG_A: work <= rnd17[nlr_pkg::OPA_W-1:0];
      ST_DG_F: begin
        sprev  <= p18;
        result <= '{function_value: p18, degree_n: m, order_m: m, last_of_run: 1'b0};
      end
      ST_DG_S: diag <= p18;
      default: ;
    endcase
  end

endmodule
